FILE: hdl/mpid_pkg.sv
// Package with shared types and encodings for the MIPS pseudo-instruction detector.
`timescale 1ns / 1ps
`default_nettype none

package mpid_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned KindW  = 4;
  localparam int unsigned RegW   = 5;
  localparam int unsigned PaddrW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_NONE = 4'd0,
    KIND_LI   = 4'd1,
    KIND_MOVE = 4'd2,
    KIND_NOP  = 4'd3,
    KIND_B    = 4'd4,
    KIND_LA   = 4'd5,
    KIND_LHU  = 4'd6,
    KIND_LW   = 4'd7,
    KIND_SW   = 4'd8,
    KIND_SH   = 4'd9
  } kind_e;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_ADDU    = 6'h21;

  // Register byte offsets
  localparam logic [PaddrW-1:0] REG_SWAP_BYTES = 3'd0;

  typedef struct packed {
    kind_e             kind;
    logic              fused;
    logic [RegW-1:0]   treg;
    logic [WordW-1:0]  addr;
  } res_t;

  typedef struct packed {
    logic [WordW-1:0] instr_word;
    logic [WordW-1:0] next_word;
    logic             next_valid;
  } item_t;

endpackage

`default_nettype wire

FILE: hdl/mpid_cfg.sv
// APB-style configuration register block holding the byte swap control.
`timescale 1ns / 1ps
`default_nettype none

module mpid_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mpid_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output logic                              swap_bytes_o
);

  logic swap_q, swap_d;
  logic wr_en;

  assign pready = 1'b1;
  // low address bits select a byte within the word and are ignored
  assign wr_en = psel & penable & pwrite &
                 (paddr[mpid_pkg::PaddrW-1] == mpid_pkg::REG_SWAP_BYTES[mpid_pkg::PaddrW-1]);

  always_comb begin
    swap_d = swap_q;
    if (wr_en) begin
      swap_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else begin
      swap_q <= swap_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[mpid_pkg::PaddrW-1] == mpid_pkg::REG_SWAP_BYTES[mpid_pkg::PaddrW-1]) begin
      prdata = {31'd0, swap_q};
    end
  end

  assign swap_bytes_o = swap_q;

endmodule

`default_nettype wire

FILE: hdl/mpid_decode.sv
// Combinational decode of one instruction pair into a pseudo-instruction result.
`timescale 1ns / 1ps
`default_nettype none

module mpid_decode (
  input  wire mpid_pkg::item_t item_i,
  input  wire logic            swap_bytes_i,
  output mpid_pkg::res_t       res_o
);

  logic [31:0] w, n;
  logic [5:0]  op, nop;
  logic [4:0]  rs, rt, rd, n_rs;
  logic [31:0] hi, lo, sx;
  logic        pair_ok;

  always_comb begin
    if (swap_bytes_i) begin
      w = {item_i.instr_word[7:0], item_i.instr_word[15:8],
           item_i.instr_word[23:16], item_i.instr_word[31:24]};
      n = {item_i.next_word[7:0], item_i.next_word[15:8],
           item_i.next_word[23:16], item_i.next_word[31:24]};
    end else begin
      w = item_i.instr_word;
      n = item_i.next_word;
    end
  end

  assign op   = w[31:26];
  assign rs   = w[25:21];
  assign rt   = w[20:16];
  assign rd   = w[15:11];
  assign nop  = n[31:26];
  assign n_rs = n[25:21];
  assign hi   = {w[15:0], 16'd0};
  assign lo   = {16'd0, n[15:0]};
  assign sx   = {{16{n[15]}}, n[15:0]};
  assign pair_ok = (op == mpid_pkg::OP_LUI) && item_i.next_valid && (rt == n_rs);

  always_comb begin
    res_o = '0;
    res_o.kind = mpid_pkg::KIND_NONE;
    case (op)
      mpid_pkg::OP_ORI, mpid_pkg::OP_ADDI, mpid_pkg::OP_ADDIU: begin
        if (rs == 5'd0) res_o.kind = mpid_pkg::KIND_LI;
      end
      mpid_pkg::OP_SPECIAL: begin
        if (w[5:0] == mpid_pkg::FN_ADDU && rt == 5'd0) begin
          res_o.kind = mpid_pkg::KIND_MOVE;
        end else if (w[5:0] == mpid_pkg::FN_SLL && rd == 5'd0 && rt == 5'd0) begin
          res_o.kind = mpid_pkg::KIND_NOP;
        end
      end
      mpid_pkg::OP_BEQ: begin
        if (rs == rt) res_o.kind = mpid_pkg::KIND_B;
      end
      default: begin
        if (pair_ok) begin
          res_o.fused = 1'b1;
          res_o.treg  = n[20:16];
          res_o.addr  = hi + sx;
          case (nop)
            mpid_pkg::OP_ORI: begin
              res_o.kind = mpid_pkg::KIND_LA;
              res_o.addr = hi | lo;
            end
            mpid_pkg::OP_ADDIU: res_o.kind = mpid_pkg::KIND_LA;
            mpid_pkg::OP_LHU:   res_o.kind = mpid_pkg::KIND_LHU;
            mpid_pkg::OP_LW:    res_o.kind = mpid_pkg::KIND_LW;
            mpid_pkg::OP_SW:    res_o.kind = mpid_pkg::KIND_SW;
            mpid_pkg::OP_SH:    res_o.kind = mpid_pkg::KIND_SH;
            default: begin
              // lui with no fusable partner
              res_o = '0;
              res_o.kind = mpid_pkg::KIND_NONE;
            end
          endcase
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/mips_pseudo_instruction_detect.sv
// Top level of the MIPS pseudo-instruction detector: input register, decode, result register.
`timescale 1ns / 1ps
`default_nettype none

// An item (instruction word, following word, next_valid) is taken on any cycle with start_i
// high; busy_o stays low, so one item per cycle is sustained. Each item is captured in an
// input register, decoded by combinational logic and its result is held in a result
// register; done_o pulses for one cycle with each new result in that register. Results come
// out in order and cannot be stalled by the receiver. The user must change swap_bytes
// (offset 0) only while no item is in flight; the block itself does not enforce this.
module mips_pseudo_instruction_detect (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [31:0]                  instr_word_i,
  input  wire logic [31:0]                  next_word_i,
  input  wire logic                         next_valid_i,
  output logic                              done_o,
  output logic [3:0]                        macro_kind_o,
  output logic                              fused_o,
  output logic [4:0]                        target_reg_o,
  output logic [31:0]                       address_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mpid_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  logic            swap_bytes;
  logic            in_vld_q, in_vld_d;
  mpid_pkg::item_t item_q, item_d;
  logic            out_vld_q, out_vld_d;
  mpid_pkg::res_t  res_q, res_d;
  logic            accept;

  mpid_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .swap_bytes_o (swap_bytes)
  );

  mpid_decode u_decode (
    .item_i       (item_q),
    .swap_bytes_i (swap_bytes),
    .res_o        (res_d)
  );

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign in_vld_d  = accept;
  assign out_vld_d = in_vld_q;

  always_comb begin
    item_d = item_q;
    if (accept) begin
      item_d.instr_word = instr_word_i;
      item_d.next_word  = next_word_i;
      item_d.next_valid = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o       = out_vld_q;
  assign macro_kind_o = res_q.kind;
  assign fused_o      = res_q.fused;
  assign target_reg_o = res_q.treg;
  assign address_o    = res_q.addr;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result without an item taken two cycles earlier");

  a_unfused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !fused_o) |-> (address_o == 32'd0 && target_reg_o == 5'd0))
    else $error("address or target register set without fusion");

  a_fused_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && fused_o) |-> (res_q.kind == mpid_pkg::KIND_LA || res_q.kind == mpid_pkg::KIND_LHU ||
                             res_q.kind == mpid_pkg::KIND_LW || res_q.kind == mpid_pkg::KIND_SW ||
                             res_q.kind == mpid_pkg::KIND_SH))
    else $error("fused result with a single-word kind");

endmodule

`default_nettype wire
